>>> hdl/tga_rle_pixel_decoder_macros.svh
// Assertion macros shared by the decoder modules.
`ifndef TGA_RLE_PIXEL_DECODER_MACROS_SVH
`define TGA_RLE_PIXEL_DECODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TGA_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tga decoder: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define TGA_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tga decoder: next-cycle check failed");

`endif

>>> hdl/tga_pkg.sv
// Types, constants and helper functions of the TGA run-length pixel decoder.
`default_nettype none
package tga_pkg;

   localparam int MAX_RUN              = 128;
   localparam int PIXEL_COUNT_BITS_DEF = 24;
   localparam int LIMIT_W              = 24;
   localparam int CSR_IDX_W            = 8;
   localparam int CSR_DATA_W           = 24;
   localparam int RUN_W                = 8;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_BYTES_PER_PIXEL = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RLE_ENABLED     = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SWAP_RED_BLUE   = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PIXEL_LIMIT     = 8'd3;

   // Register reset values and the four-byte pixel size
   localparam logic [2:0]         BPP_RESET   = 3'd3;
   localparam logic [2:0]         BPP_FOUR    = 3'd4;
   localparam logic               RLE_RESET   = 1'b1;
   localparam logic               SWAP_RESET  = 1'b1;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'hFFFFFF;

   typedef struct packed {
      logic [2:0]         bytes_per_pixel;
      logic               rle_enabled;
      logic               swap_red_blue;
      logic [LIMIT_W-1:0] pixel_limit;
   } tga_cfg_type;

   typedef struct packed {
      logic accept;   // take the input byte this cycle
      logic emit;     // load one result into the output register
   } tga_cmd_type;

   typedef struct packed {
      logic pixel_out;  // the offered byte completes a pixel that must be emitted
      logic last_emit;  // the pending run fits in one more result
      logic out_free;   // the output register can take a result
   } tga_sts_type;

   // Exchange bytes 0 and 2 when swapping is on.
   function automatic logic [31:0] finish_pixel(input logic [31:0] p, input logic swap);
      logic [31:0] r;
      r = p;
      if (swap) begin
         r = {p[31:24], p[7:0], p[15:8], p[23:16]};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> hdl/tga_if.sv
// Handshake channel interfaces of the decoder: byte input, pixel output, register writes.
`default_nettype none
interface tga_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       frame_start;
   modport source (output valid, output data_byte, output frame_start, input ready);
   modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface tga_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] pixel_first;
   logic [31:0] pixel_second;
   logic [1:0]  pixel_count;
   logic        last_of_run;
   logic        frame_done;
   modport source (output valid, output pixel_first, output pixel_second,
                   output pixel_count, output last_of_run, output frame_done,
                   input ready);
   modport sink   (input valid, input pixel_first, input pixel_second,
                   input pixel_count, input last_of_run, input frame_done,
                   output ready);
endinterface

interface tga_csr_if;
   logic                           valid;
   logic                           ready;
   logic [tga_pkg::CSR_IDX_W-1:0]  index;
   logic [tga_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/tga_csr.sv
// Configuration register bank of the decoder.
`default_nettype none
module tga_csr (
   input  wire                  clock,
   input  wire                  reset,
   tga_csr_if.sink              csr_bus,
   output tga_pkg::tga_cfg_type cfg
);

   tga_pkg::tga_cfg_type cfg_ff, cfg_in;

   assign csr_bus.ready = 1'b1;
   assign cfg = cfg_ff;

   // Decode the write index; keep only each register's low bits
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            tga_pkg::REG_BYTES_PER_PIXEL: cfg_in.bytes_per_pixel = csr_bus.data[2:0];
            tga_pkg::REG_RLE_ENABLED:     cfg_in.rle_enabled     = csr_bus.data[0];
            tga_pkg::REG_SWAP_RED_BLUE:   cfg_in.swap_red_blue   = csr_bus.data[0];
            tga_pkg::REG_PIXEL_LIMIT:     cfg_in.pixel_limit     =
               csr_bus.data[tga_pkg::LIMIT_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bytes_per_pixel <= tga_pkg::BPP_RESET;
         cfg_ff.rle_enabled     <= tga_pkg::RLE_RESET;
         cfg_ff.swap_red_blue   <= tga_pkg::SWAP_RESET;
         cfg_ff.pixel_limit     <= tga_pkg::LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

>>> hdl/tga_ctrl.sv
// Controller state machine: accepts bytes, then sequences the output of a pixel run.
`default_nettype none
`include "tga_rle_pixel_decoder_macros.svh"
module tga_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  tga_pkg::tga_sts_type sts,
   output tga_pkg::tga_cmd_type cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EMIT = 1'b1;

   logic state_ff, state_in;

   // Take bytes only while no run is being emitted
   assign req_ready  = (state_ff == ST_IDLE);
   assign cmd.accept = req_valid && (state_ff == ST_IDLE);
   assign cmd.emit   = (state_ff == ST_EMIT) && sts.out_free;

   // Advance on a completed pixel, return after the last result of the run
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.accept && sts.pixel_out) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (cmd.emit && sts.last_emit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `TGA_ASSERT_NEXT(a_pixel_starts_emit, clock, reset, cmd.accept && sts.pixel_out, state_ff == ST_EMIT)
   `TGA_ASSERT_NEXT(a_last_result_idles, clock, reset, cmd.emit && sts.last_emit, state_ff == ST_IDLE)
   `TGA_ASSERT_NOW(a_no_accept_and_emit, clock, reset, cmd.emit, !cmd.accept)

endmodule
`default_nettype wire

>>> hdl/tga_dpath.sv
// Datapath: packet and pixel state, pixel assembly, run clipping and the output register.
`default_nettype none
`include "tga_rle_pixel_decoder_macros.svh"
module tga_dpath #(
   parameter int PIXEL_COUNT_BITS = tga_pkg::PIXEL_COUNT_BITS_DEF
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire [7:0]            data_byte,
   input  wire                  frame_start,
   input  tga_pkg::tga_cfg_type cfg,
   input  tga_pkg::tga_cmd_type cmd,
   output tga_pkg::tga_sts_type sts,
   tga_rsp_if.source            rsp_bus
);

   localparam int CW = (PIXEL_COUNT_BITS > tga_pkg::LIMIT_W) ?
                       PIXEL_COUNT_BITS : tga_pkg::LIMIT_W;
   localparam int RW = tga_pkg::RUN_W;
   localparam logic [PIXEL_COUNT_BITS-1:0] COUNT_MAX = '1;

   // Decoder state
   logic                        hdr_ff, hdr_in;
   logic                        run_ff, run_in;
   logic [RW-1:0]               left_ff, left_in;
   logic [1:0]                  idx_ff, idx_in;
   logic [31:0]                 asm_ff, asm_in;
   logic [PIXEL_COUNT_BITS-1:0] emitted_ff, emitted_in;
   // Run being emitted
   logic [31:0]                 pix_ff, pix_in;
   logic [RW-1:0]               emit_left_ff, emit_left_in;
   // Output register
   logic                        out_valid_ff, out_valid_in;
   logic [31:0]                 out_first_ff, out_first_in;
   logic [31:0]                 out_second_ff, out_second_in;
   logic [1:0]                  out_count_ff, out_count_in;
   logic                        out_last_ff, out_last_in;
   logic                        out_done_ff, out_done_in;

   // Values seen by the accepted byte after an optional frame restart
   logic                        hdr_e, run_e;
   logic [RW-1:0]               left_e;
   logic [1:0]                  idx_e;
   logic [31:0]                 asm_e;
   logic [PIXEL_COUNT_BITS-1:0] emitted_e;

   logic [CW-1:0]   emitted_x, limit_x, rem_x;
   logic            frame_full, is_header, complete;
   logic [1:0]      last_idx;
   logic [31:0]     asm_new;
   logic [RW-1:0]   left_dec, n_raw, n_clip;
   logic            two;
   logic [RW-1:0]   emit_step_left;
   logic [PIXEL_COUNT_BITS:0] emit_sum;
   logic [PIXEL_COUNT_BITS-1:0] emit_count;

   assign hdr_e     = frame_start ? 1'b1 : hdr_ff;
   assign run_e     = frame_start ? 1'b0 : run_ff;
   assign left_e    = frame_start ? '0 : left_ff;
   assign idx_e     = frame_start ? 2'd0 : idx_ff;
   assign asm_e     = frame_start ? 32'd0 : asm_ff;
   assign emitted_e = frame_start ? '0 : emitted_ff;

   // Pixels still allowed in this frame
   assign emitted_x  = CW'(emitted_e);
   assign limit_x    = CW'(cfg.pixel_limit);
   assign frame_full = (emitted_x >= limit_x);
   assign rem_x      = limit_x - emitted_x;

   assign is_header = cfg.rle_enabled && hdr_e;
   assign last_idx  = (cfg.bytes_per_pixel == tga_pkg::BPP_FOUR) ? 2'd3 : 2'd2;
   assign complete  = (idx_e >= last_idx);

   // Insert the byte into the pixel under assembly
   always_comb begin
      asm_new = (idx_e == 2'd0) ? 32'd0 : asm_e;
      asm_new[8*idx_e +: 8] = data_byte;
   end

   assign left_dec = (left_e != '0) ? left_e - RW'(1) : '0;

   // Pixel count of this byte: whole run, or one literal; clip at the limit
   always_comb begin
      if (!cfg.rle_enabled) begin
         n_raw = RW'(1);
      end else if (run_e) begin
         n_raw = (left_e != '0) ? left_e : RW'(1);
      end else begin
         n_raw = RW'(1);
      end
      n_clip = (CW'(n_raw) > rem_x) ? rem_x[RW-1:0] : n_raw;
   end

   assign sts.pixel_out = !frame_full && !is_header && complete;
   assign sts.last_emit = (emit_left_ff <= RW'(2));
   assign sts.out_free  = !out_valid_ff || rsp_bus.ready;

   // One result of the run: two pixels while at least two remain
   assign two            = (emit_left_ff >= RW'(2));
   assign emit_step_left = emit_left_ff - (two ? RW'(2) : RW'(1));
   assign emit_sum       = {1'b0, emitted_ff} + (two ? (PIXEL_COUNT_BITS+1)'(2)
                                                     : (PIXEL_COUNT_BITS+1)'(1));
   assign emit_count     = emit_sum[PIXEL_COUNT_BITS] ? COUNT_MAX
                                                      : emit_sum[PIXEL_COUNT_BITS-1:0];

   // Next state of the decoder and the run
   always_comb begin
      hdr_in       = hdr_ff;
      run_in       = run_ff;
      left_in      = left_ff;
      idx_in       = idx_ff;
      asm_in       = asm_ff;
      emitted_in   = emitted_ff;
      pix_in       = pix_ff;
      emit_left_in = emit_left_ff;
      if (cmd.accept) begin
         hdr_in     = hdr_e;
         run_in     = run_e;
         left_in    = left_e;
         idx_in     = idx_e;
         asm_in     = asm_e;
         emitted_in = emitted_e;
         if (!frame_full) begin
            if (is_header) begin
               // Packet header: raw count or run length
               if (data_byte < 8'(tga_pkg::MAX_RUN)) begin
                  run_in  = 1'b0;
                  left_in = RW'(data_byte) + RW'(1);
               end else begin
                  run_in  = 1'b1;
                  left_in = RW'(data_byte - 8'(tga_pkg::MAX_RUN - 1));
               end
               hdr_in = 1'b0;
               idx_in = 2'd0;
            end else begin
               asm_in = asm_new;
               if (!complete) begin
                  idx_in = idx_e + 2'd1;
               end else begin
                  idx_in       = 2'd0;
                  pix_in       = tga_pkg::finish_pixel(asm_new, cfg.swap_red_blue);
                  emit_left_in = n_clip;
                  if (cfg.rle_enabled) begin
                     if (run_e) begin
                        left_in = '0;
                        hdr_in  = 1'b1;
                     end else begin
                        left_in = left_dec;
                        if (left_dec == '0) begin
                           hdr_in = 1'b1;
                        end
                     end
                  end
               end
            end
         end
      end else if (cmd.emit) begin
         emit_left_in = emit_step_left;
         emitted_in   = emit_count;
      end
   end

   // Load or drain the output register
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_first_in  = out_first_ff;
      out_second_in = out_second_ff;
      out_count_in  = out_count_ff;
      out_last_in   = out_last_ff;
      out_done_in   = out_done_ff;
      if (cmd.emit) begin
         out_valid_in  = 1'b1;
         out_first_in  = pix_ff;
         out_second_in = two ? pix_ff : 32'd0;
         out_count_in  = two ? 2'd2 : 2'd1;
         out_last_in   = (emit_step_left == '0);
         out_done_in   = (CW'(emit_count) >= limit_x);
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff       <= 1'b1;
         run_ff       <= 1'b0;
         left_ff      <= '0;
         idx_ff       <= 2'd0;
         asm_ff       <= 32'd0;
         emitted_ff   <= '0;
         emit_left_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         hdr_ff       <= hdr_in;
         run_ff       <= run_in;
         left_ff      <= left_in;
         idx_ff       <= idx_in;
         asm_ff       <= asm_in;
         emitted_ff   <= emitted_in;
         emit_left_ff <= emit_left_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff        <= pix_in;
      out_first_ff  <= out_first_in;
      out_second_ff <= out_second_in;
      out_count_ff  <= out_count_in;
      out_last_ff   <= out_last_in;
      out_done_ff   <= out_done_in;
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.pixel_first  = out_first_ff;
   assign rsp_bus.pixel_second = out_second_ff;
   assign rsp_bus.pixel_count  = out_count_ff;
   assign rsp_bus.last_of_run  = out_last_ff;
   assign rsp_bus.frame_done   = out_done_ff;

   `TGA_ASSERT_NEXT(a_run_loaded, clock, reset, cmd.accept && sts.pixel_out, emit_left_ff != '0)
   `TGA_ASSERT_NOW(a_emit_has_pixels, clock, reset, cmd.emit, emit_left_ff != '0)

endmodule
`default_nettype wire

>>> hdl/tga_rle_pixel_decoder.sv
// Top level of the TGA run-length pixel decoder.
// Takes one stream byte per accepted req transaction and returns pixels on rsp, up to two per
// transaction. A packet header byte, or a pixel byte that does not finish a pixel, is taken
// with no output. The byte that finishes a pixel moves the controller to its emit state, which
// issues ceil(n/2) results for n repeated pixels, so up to 64 results for a 128-pixel run
// packet, one result per cycle while rsp is ready. The single output register, filled with
// two copies of the pixel per result, sets that rate; input is held off while a run drains.
// Decoding stops at pixel_limit; further bytes are taken and dropped until frame_start.
// Registers (csr index): 0 bytes_per_pixel, 1 rle_enabled, 2 swap_red_blue, 3 pixel_limit;
// write them only while the decoder is idle.
`default_nettype none
module tga_rle_pixel_decoder #(
   parameter int PIXEL_COUNT_BITS = tga_pkg::PIXEL_COUNT_BITS_DEF
) (
   input  wire       clock,
   input  wire       reset,
   tga_req_if.sink   req_bus,
   tga_rsp_if.source rsp_bus,
   tga_csr_if.sink   csr_bus
);

   tga_pkg::tga_cfg_type cfg;
   tga_pkg::tga_cmd_type cmd;
   tga_pkg::tga_sts_type sts;

   tga_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   tga_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tga_dpath #(
      .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .data_byte   (req_bus.data_byte),
      .frame_start (req_bus.frame_start),
      .cfg         (cfg),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_bus     (rsp_bus)
   );

endmodule
`default_nettype wire

>>> bench/tb_tga_rle_pixel_decoder.sv
// Self-checking testbench of the TGA run-length pixel decoder: byte stream in, pixel pairs out.
module tb_tga_rle_pixel_decoder;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT  = 2000;  // cycles with no transaction on any channel
   localparam int HOLD_CYCLES  = 300;   // long receiver hold-off, fills the decoder
   localparam int DRAIN_CYCLES = 16;    // settle time after the last pixel pair
   localparam int PHASES       = 5;
   localparam int PHASE_BYTES  = 24;

   // Index past the last register, must be ignored
   localparam logic [tga_pkg::CSR_IDX_W-1:0] REG_UNUSED = 8'd7;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
   } stream_byte_type;

   typedef struct packed {
      logic [31:0] pixel_first;
      logic [31:0] pixel_second;
      logic [1:0]  pixel_count;
      logic        last_of_run;
      logic        frame_done;
   } pixel_pair_type;

   logic clock = 1'b0;
   logic reset;

   tga_req_if req_bus ();
   tga_rsp_if rsp_bus ();
   tga_csr_if csr_bus ();

   tga_rle_pixel_decoder u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Register mirror
   logic [2:0]                  cfg_bpp;
   logic                        cfg_rle;
   logic                        cfg_swap;
   logic [tga_pkg::LIMIT_W-1:0] cfg_limit;

   // Decoder state mirror
   logic                        hdr_phase;
   logic                        run_packet;
   logic [7:0]                  pixels_left;
   logic [1:0]                  byte_pos;
   logic [31:0]                 pixel_acc;
   logic [tga_pkg::LIMIT_W-1:0] pixels_out;

   stream_byte_type pending_bytes[$];
   pixel_pair_type  expected_pixels[$];
   stream_byte_type current_byte;

   logic offering;
   int   gap_left;
   int   stall_left;
   int   hold_left;
   logic hold_request;
   int   quiet_cycles;
   bit   steady = 1'b0;
   int   error_count = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Mostly short gaps, a few long ones; none while a steady stretch runs.
   function automatic int idle_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (steady) return 0;
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void clear_decoder();
      hdr_phase   = 1'b1;
      run_packet  = 1'b0;
      pixels_left = 8'd0;
      byte_pos    = 2'd0;
      pixel_acc   = 32'd0;
      pixels_out  = '0;
   endfunction

   // Queue n copies of pixel p, two per pixel pair, and advance the frame count.
   task automatic queue_pixels(input logic [31:0] p, input int unsigned n);
      pixel_pair_type r;
      int unsigned    c;
      int unsigned    total;
      while (n > 0) begin
         c = (n >= 2) ? 2 : 1;
         n -= c;
         total = pixels_out + c;
         if (total > 32'h00FF_FFFF) total = 32'h00FF_FFFF;
         pixels_out     = total[tga_pkg::LIMIT_W-1:0];
         r.pixel_first  = p;
         r.pixel_second = (c == 2) ? p : 32'd0;
         r.pixel_count  = c[1:0];
         r.last_of_run  = (n == 0);
         r.frame_done   = (pixels_out >= cfg_limit);
         expected_pixels.push_back(r);
      end
   endtask

   // Work out the pixel pairs that one stream byte causes.
   task automatic decode_stream_byte(input stream_byte_type s);
      logic [1:0]  last_pos;
      int unsigned remaining;
      int unsigned n;
      logic [31:0] p;
      last_pos = (cfg_bpp == tga_pkg::BPP_FOUR) ? 2'd3 : 2'd2;
      if (s.frame_start) clear_decoder();
      remaining = (pixels_out >= cfg_limit) ? 0 : cfg_limit - pixels_out;
      if (remaining == 0) return;
      // packet header: consume it, no output
      if (cfg_rle && hdr_phase) begin
         run_packet  = (s.data_byte >= tga_pkg::MAX_RUN);
         pixels_left = run_packet ? 8'(s.data_byte - (tga_pkg::MAX_RUN - 1))
                                  : 8'(s.data_byte + 1);
         hdr_phase   = 1'b0;
         byte_pos    = 2'd0;
         return;
      end
      if (byte_pos == 2'd0) pixel_acc = 32'd0;
      pixel_acc[8*byte_pos +: 8] = s.data_byte;
      // a pixel completes once the position reaches or passes the last byte
      if (byte_pos < last_pos) begin
         byte_pos = byte_pos + 2'd1;
         return;
      end
      byte_pos = 2'd0;
      p = cfg_swap ? {pixel_acc[31:24], pixel_acc[7:0], pixel_acc[15:8], pixel_acc[23:16]}
                   : pixel_acc;
      n = 1;
      if (cfg_rle) begin
         if (run_packet) begin
            n           = 32'(pixels_left);
            pixels_left = 8'd0;
         end else if (pixels_left != 8'd0) begin
            pixels_left = pixels_left - 8'd1;
         end
         if (pixels_left == 8'd0) hdr_phase = 1'b1;
         if (n == 0) n = 1;
         if (n > remaining) n = remaining;
      end
      queue_pixels(p, n);
   endtask

   task automatic push_byte(input logic [7:0] d, input logic fs);
      stream_byte_type s;
      s.data_byte   = d;
      s.frame_start = fs;
      pending_bytes.push_back(s);
   endtask

   // Write one register and track it in the mirror once the transaction is taken.
   task automatic write_reg(input logic [tga_pkg::CSR_IDX_W-1:0] idx,
                            input logic [tga_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      csr_bus.valid <= 1'b0;
      case (idx)
         tga_pkg::REG_BYTES_PER_PIXEL: cfg_bpp   = value[2:0];
         tga_pkg::REG_RLE_ENABLED:     cfg_rle   = value[0];
         tga_pkg::REG_SWAP_RED_BLUE:   cfg_swap  = value[0];
         tga_pkg::REG_PIXEL_LIMIT:     cfg_limit = value[tga_pkg::LIMIT_W-1:0];
         default: ;
      endcase
   endtask

   // Hold until every byte is taken and every pixel pair has come back.
   task automatic wait_idle();
      while (pending_bytes.size() != 0 || offering || expected_pixels.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Pick new settings, upper data bits random so only the low bits may count.
   task automatic randomize_settings();
      logic [tga_pkg::CSR_DATA_W-1:0] v;
      int unsigned                    r;
      if ($urandom_range(0, 9) < 7) begin
         v = tga_pkg::CSR_DATA_W'($urandom);
         if ($urandom_range(0, 4) != 0)
            v[2:0] = $urandom_range(0, 1) ? tga_pkg::BPP_FOUR : tga_pkg::BPP_RESET;
         write_reg(tga_pkg::REG_BYTES_PER_PIXEL, v);
      end
      if ($urandom_range(0, 9) < 7) begin
         v    = tga_pkg::CSR_DATA_W'($urandom);
         v[0] = ($urandom_range(0, 4) != 0);
         write_reg(tga_pkg::REG_RLE_ENABLED, v);
      end
      if ($urandom_range(0, 9) < 7) begin
         v = tga_pkg::CSR_DATA_W'($urandom);
         write_reg(tga_pkg::REG_SWAP_RED_BLUE, v);
      end
      if ($urandom_range(0, 9) < 8) begin
         r = $urandom_range(0, 99);
         if (r < 10)      v = 24'd1;
         else if (r < 50) v = tga_pkg::CSR_DATA_W'($urandom_range(2, 60));
         else if (r < 80) v = tga_pkg::CSR_DATA_W'($urandom_range(61, 2000));
         else             v = tga_pkg::LIMIT_RESET;
         write_reg(tga_pkg::REG_PIXEL_LIMIT, v);
      end
   endtask

   // Mostly well-formed packets with random content, some noise and cut packets; raw bytes without RLE.
   task automatic generate_stream(input int unsigned budget, input bit new_frame);
      int unsigned made;
      int unsigned pix_bytes;
      int unsigned hdr;
      int unsigned nbytes;
      int unsigned r;
      bit          start;
      made      = 0;
      start     = new_frame;
      pix_bytes = (cfg_bpp == tga_pkg::BPP_FOUR) ? 4 : 3;
      while (made < budget) begin
         r = $urandom_range(0, 99);
         if (!cfg_rle) begin
            push_byte(8'($urandom), start || (r < 3));
            made++;
         end else if (r < 8) begin
            push_byte(8'($urandom), $urandom_range(0, 3) == 0);
            made++;
         end else begin
            if (r < 55)
               hdr = ($urandom_range(0, 6) == 0) ? $urandom_range(4, 127) : $urandom_range(0, 3);
            else
               hdr = $urandom_range(tga_pkg::MAX_RUN, 255);
            push_byte(8'(hdr), start || ($urandom_range(0, 3) == 0));
            made++;
            nbytes = ((hdr < tga_pkg::MAX_RUN) ? ((hdr + 1 > 6) ? 6 : hdr + 1) : 1) * pix_bytes;
            // cut the packet short now and then
            if ($urandom_range(0, 19) == 0) nbytes = $urandom_range(0, nbytes - 1);
            repeat (nbytes) begin
               push_byte(8'($urandom), 1'b0);
               made++;
            end
         end
         start = 1'b0;
      end
   endtask

   // Offer queued stream bytes on req, with random gaps between transactions.
   always @(posedge clock) begin : drive_bytes
      logic next_valid;
      next_valid = req_bus.valid;
      if (reset) begin
         next_valid          = 1'b0;
         offering            = 1'b0;
         gap_left            = 0;
         req_bus.data_byte   <= 8'd0;
         req_bus.frame_start <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            decode_stream_byte(current_byte);
            offering   = 1'b0;
            next_valid = 1'b0;
         end
         if (!offering) begin
            if (gap_left != 0) begin
               gap_left--;
            end else if (pending_bytes.size() != 0) begin
               current_byte        = pending_bytes.pop_front();
               req_bus.data_byte   <= current_byte.data_byte;
               req_bus.frame_start <= current_byte.frame_start;
               next_valid          = 1'b1;
               offering            = 1'b1;
               gap_left            = idle_length();
            end
         end
      end
      req_bus.valid <= next_valid;
   end

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         error_count++;
      end
   endfunction

   // Compare each pixel pair with the oldest expectation; stall the receiver at random.
   always @(posedge clock) begin : check_pixels
      pixel_pair_type got;
      pixel_pair_type want;
      logic           next_ready;
      if (reset) begin
         next_ready = 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = {rsp_bus.pixel_first, rsp_bus.pixel_second, rsp_bus.pixel_count,
                   rsp_bus.last_of_run, rsp_bus.frame_done};
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected rsp transaction, expected none, actual %h",
                        $time, got);
               error_count++;
            end else begin
               want = expected_pixels.pop_front();
               check_field("pixel_first",  want.pixel_first,  got.pixel_first);
               check_field("pixel_second", want.pixel_second, got.pixel_second);
               check_field("pixel_count",  32'(want.pixel_count), 32'(got.pixel_count));
               check_field("last_of_run",  32'(want.last_of_run), 32'(got.last_of_run));
               check_field("frame_done",   32'(want.frame_done),  32'(got.frame_done));
            end
         end
         if (hold_left != 0) begin
            next_ready = 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            next_ready = 1'b0;
         end else begin
            next_ready = 1'b1;
            stall_left = idle_length();
         end
      end
      rsp_bus.ready <= next_ready;
   end

   // Count down the long receiver hold-off once requested.
   always @(posedge clock) begin : receiver_hold
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_request) begin
         hold_left <= HOLD_CYCLES;
      end
   end

   // End the run when no channel moves a transaction for too long.
   always @(posedge clock) begin : watchdog
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: timeout, %0d pixel pairs still expected", $time,
                  expected_pixels.size());
         $display("tb_tga_rle_pixel_decoder: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [tga_pkg::CSR_DATA_W-1:0] v;
      reset                = 1'b1;
      csr_bus.valid        = 1'b0;
      csr_bus.index        = '0;
      csr_bus.data         = '0;
      hold_request         = 1'b0;
      cfg_bpp              = tga_pkg::BPP_RESET;
      cfg_rle              = tga_pkg::RLE_RESET;
      cfg_swap             = tga_pkg::SWAP_RESET;
      cfg_limit            = tga_pkg::LIMIT_RESET;
      clear_decoder();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Raw packet of two pixels, then the shortest and the longest run packet.
      push_byte(8'h01, 1'b1);
      push_byte(8'h00, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'h12, 1'b0);
      push_byte(8'h34, 1'b0); push_byte(8'h56, 1'b0); push_byte(8'h78, 1'b0);
      push_byte(8'h80, 1'b0);
      push_byte(8'hAB, 1'b0); push_byte(8'hCD, 1'b0); push_byte(8'hEF, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'hFF, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h5A, 1'b0);
      wait_idle();

      // Clip a run packet at a small limit; drop the byte after it.
      write_reg(tga_pkg::REG_PIXEL_LIMIT, 24'd3);
      write_reg(tga_pkg::REG_SWAP_RED_BLUE, 24'd0);
      push_byte(8'h84, 1'b1);
      push_byte(8'h11, 1'b0); push_byte(8'h22, 1'b0); push_byte(8'h33, 1'b0);
      push_byte(8'h44, 1'b0);
      wait_idle();

      // Zero limit finishes the frame at once.
      write_reg(tga_pkg::REG_PIXEL_LIMIT, 24'd0);
      push_byte(8'h00, 1'b1);
      wait_idle();

      // Pass four-byte pixels through, leave byte 3 of a pixel pending.
      write_reg(tga_pkg::REG_RLE_ENABLED, 24'd0);
      write_reg(tga_pkg::REG_BYTES_PER_PIXEL, 24'd4);
      write_reg(tga_pkg::REG_PIXEL_LIMIT, tga_pkg::LIMIT_RESET);
      push_byte(8'hC3, 1'b1);
      push_byte(8'h3C, 1'b0); push_byte(8'hA5, 1'b0); push_byte(8'h5A, 1'b0);
      push_byte(8'h01, 1'b0); push_byte(8'h80, 1'b0); push_byte(8'h7F, 1'b0);
      wait_idle();

      // Shrink the pixel size mid-pixel; the pending position already passes the end.
      write_reg(tga_pkg::REG_BYTES_PER_PIXEL, 24'd3);
      write_reg(REG_UNUSED, 24'h00ABCD);
      push_byte(8'h99, 1'b0);
      wait_idle();

      // Random phases; the second one holds the receiver off under run packets.
      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase == 1) begin
            v    = tga_pkg::CSR_DATA_W'($urandom);
            v[2:0] = $urandom_range(0, 1) ? tga_pkg::BPP_FOUR : tga_pkg::BPP_RESET;
            write_reg(tga_pkg::REG_BYTES_PER_PIXEL, v);
            write_reg(tga_pkg::REG_RLE_ENABLED, 24'd1);
            write_reg(tga_pkg::REG_PIXEL_LIMIT, tga_pkg::LIMIT_RESET);
            steady = 1'b1;
            @(posedge clock);
            hold_request <= 1'b1;
            @(posedge clock);
            hold_request <= 1'b0;
            generate_stream(PHASE_BYTES, 1'b1);
         end else begin
            randomize_settings();
            steady = ($urandom_range(0, 3) == 0);
            generate_stream(PHASE_BYTES, $urandom_range(0, 4) != 0);
         end
         wait_idle();
      end

      if (expected_pixels.size() != 0) begin
         $display("%0t: %0d pixel pairs never arrived", $time, expected_pixels.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("tb_tga_rle_pixel_decoder: clean");
      end else begin
         $display("tb_tga_rle_pixel_decoder: errors");
      end
      $finish;
   end

endmodule
